// ===== hdl/ssdp_pkg.sv =====
// shared types, constants and character tables for the ssdp m-search parser
`timescale 1ns / 1ps

package ssdp_pkg;

  // first request line status
  localparam logic [3:0] RL_CHECK = 4'd8;
  localparam logic [3:0] RL_FIRST = 4'd9;
  localparam logic [3:0] RL_HEAD  = 4'd10;
  localparam logic [3:0] RL_FAIL  = 4'd15;

  // header name matcher codes
  localparam logic [3:0] NM_IDLE = 4'd0;
  localparam logic [3:0] NM_H    = 4'd1;
  localparam logic [3:0] NM_HO   = 4'd2;
  localparam logic [3:0] NM_HOS  = 4'd3;
  localparam logic [3:0] NM_HOST = 4'd4;
  localparam logic [3:0] NM_S    = 4'd5;
  localparam logic [3:0] NM_ST   = 4'd6;
  localparam logic [3:0] NM_M    = 4'd7;
  localparam logic [3:0] NM_MA   = 4'd8;
  localparam logic [3:0] NM_MAN  = 4'd9;
  localparam logic [3:0] NM_MX   = 4'd10;
  localparam logic [3:0] NM_DEAD = 4'd15;

  // header flag bit positions
  localparam int HF_HOST   = 0;
  localparam int HF_ST     = 1;
  localparam int HF_MATCH  = 2;
  localparam int HF_MAN    = 3;
  localparam int HF_MX     = 4;
  localparam int HF_BADMAN = 5;

  localparam logic [3:0] ST_ALL_LEN  = 4'd8;
  localparam logic [3:0] ST_ROOT_LEN = 4'd15;
  localparam logic [3:0] MAN_LEN     = 4'd15;
  localparam logic [2:0] NOTIFY_LEN  = 3'd7;
  localparam logic [7:0] MX_LIMIT    = 8'd120;
  localparam logic [7:0] MX_SAT      = 8'd255;

  typedef enum logic [2:0] {
    PH_NAME  = 3'd0,
    PH_SEP1  = 3'd1,
    PH_SEP2  = 3'd2,
    PH_VALUE = 3'd3,
    PH_MXPRE = 3'd4,
    PH_MXDIG = 3'd5,
    PH_SKIP  = 3'd6
  } line_phase_t;

  typedef enum logic [2:0] {
    V_REPLY    = 3'd0,
    V_NOTIFY   = 3'd1,
    V_NOT_MSRC = 3'd2,
    V_BAD_MAN  = 3'd3,
    V_INVALID  = 3'd4,
    V_FOREIGN  = 3'd5
  } verdict_t;

  typedef struct packed {
    line_phase_t phase;
    logic [3:0]  name_prog;
    logic [4:0]  val_prog;
    logic [5:0]  flags;
    logic [7:0]  mx_value;
    logic        mx_neg;
  } hdr_state_t;

  typedef struct packed {
    logic [2:0] notify_prog;
    logic       notify_found;
    logic       content_ended;
    logic [3:0] rl_status;
    hdr_state_t hdr;
  } parse_state_t;

  localparam hdr_state_t HDR_RESET = '{
    phase: PH_NAME, name_prog: NM_IDLE, val_prog: 5'd0,
    flags: 6'd0, mx_value: 8'd0, mx_neg: 1'b0
  };

  localparam parse_state_t PARSE_RESET = '{
    notify_prog: 3'd0, notify_found: 1'b0, content_ended: 1'b0,
    rl_status: 4'd0, hdr: HDR_RESET
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == "_") || (c == "-");
  endfunction

  function automatic logic [7:0] notify_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "N";
      3'd1: r = "O";
      3'd2: r = "T";
      3'd3: r = "I";
      3'd4: r = "F";
      3'd5: r = "Y";
      3'd6: r = " ";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] msearch_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "M";
      3'd1: r = "-";
      3'd2: r = "S";
      3'd3: r = "E";
      3'd4: r = "A";
      3'd5: r = "R";
      3'd6: r = "C";
      3'd7: r = "H";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] st_all_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "s";
      4'd1: r = "s";
      4'd2: r = "d";
      4'd3: r = "p";
      4'd4: r = ":";
      4'd5: r = "a";
      4'd6: r = "l";
      4'd7: r = "l";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] st_root_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0:  r = "u";
      4'd1:  r = "p";
      4'd2:  r = "n";
      4'd3:  r = "p";
      4'd4:  r = ":";
      4'd5:  r = "r";
      4'd6:  r = "o";
      4'd7:  r = "o";
      4'd8:  r = "t";
      4'd9:  r = "d";
      4'd10: r = "e";
      4'd11: r = "v";
      4'd12: r = "i";
      4'd13: r = "c";
      4'd14: r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] man_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0:  r = 8'h22;
      4'd1:  r = "s";
      4'd2:  r = "s";
      4'd3:  r = "d";
      4'd4:  r = "p";
      4'd5:  r = ":";
      4'd6:  r = "d";
      4'd7:  r = "i";
      4'd8:  r = "s";
      4'd9:  r = "c";
      4'd10: r = "o";
      4'd11: r = "v";
      4'd12: r = "e";
      4'd13: r = "r";
      4'd14: r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // case-insensitive walk over host / st / man / mx
  function automatic logic [3:0] name_next(input logic [3:0] p, input logic [7:0] c);
    logic [7:0] lc;
    logic [3:0] r;
    lc = ((c >= "A") && (c <= "Z")) ? (c | 8'h20) : c;
    r  = NM_DEAD;
    case (p)
      NM_IDLE: begin
        if (lc == "h") r = NM_H;
        else if (lc == "s") r = NM_S;
        else if (lc == "m") r = NM_M;
      end
      NM_H:   if (lc == "o") r = NM_HO;
      NM_HO:  if (lc == "s") r = NM_HOS;
      NM_HOS: if (lc == "t") r = NM_HOST;
      NM_S:   if (lc == "t") r = NM_ST;
      NM_M: begin
        if (lc == "a") r = NM_MA;
        else if (lc == "x") r = NM_MX;
      end
      NM_MA:  if (lc == "n") r = NM_MAN;
      default: r = NM_DEAD;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ssdp_msearch_header_parser.sv =====
// top level: ssdp m-search request checker, one payload byte per transfer
`timescale 1ns / 1ps

// channel  signals                                  carries
// -------  ---------------------------------------  -------------------------------
// in       in_valid, in_ready, payload_byte,        one udp payload byte, last flag
//          last_byte
// out      out_valid, out_ready, verdict,           one verdict per datagram
//          reply_delay
//
// one byte per cycle sustained unless a held-back verdict stalls the input; a byte
// waits in the input register and its state update happens as it leaves, so the
// verdict is computed as the last byte leaves and is held in the result register
// rst is synchronous and clears the input and result valid bits and the parser state
// a pending verdict that is not taken stalls the input register only when the byte
// held there is the last of its datagram; other bytes keep flowing

module ssdp_msearch_header_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] payload_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] verdict,
  output logic [6:0] reply_delay
);

  // input register
  logic       in_full;
  logic [7:0] byte_r;
  logic       last_r;

  // parser state and its next value
  ssdp_pkg::parse_state_t pstate;
  ssdp_pkg::parse_state_t pstate_next;

  ssdp_pkg::verdict_t v_comb;
  logic [6:0]         delay_comb;
  logic               step;

  // a held byte moves on unless it would produce a verdict with the result slot busy
  assign step     = in_full && (!last_r || !out_valid || out_ready);
  assign in_ready = !in_full || step;

  ssdp_byte_step u_step (
    .c   (byte_r),
    .cur (pstate),
    .nxt (pstate_next)
  );

  // verdict sees the state after the last byte has been applied
  ssdp_verdict u_verdict (
    .st          (pstate_next),
    .verdict     (v_comb),
    .reply_delay (delay_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= payload_byte;
      last_r <= last_byte;
    end
  end

  // parser state returns to reset after every verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= ssdp_pkg::PARSE_RESET;
    end else if (step) begin
      pstate <= last_r ? ssdp_pkg::PARSE_RESET : pstate_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && last_r) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_r) begin
      verdict     <= v_comb;
      reply_delay <= delay_comb;
    end
  end

endmodule

// ===== hdl/ssdp_hdr_step.sv =====
// next-state logic for one byte of a header line
`timescale 1ns / 1ps

module ssdp_hdr_step (
  input  logic [7:0]          c,
  input  ssdp_pkg::hdr_state_t cur,
  output ssdp_pkg::hdr_state_t nxt
);

  ssdp_pkg::line_phase_t ph;
  logic        done;
  logic [4:0]  vp;
  logic [4:0]  vp_inc;
  logic [7:0]  tc;
  logic [3:0]  len;
  logic        is_st;
  logic [11:0] mx_wide;

  assign is_st   = (cur.name_prog == ssdp_pkg::NM_ST);
  assign mx_wide = {4'd0, cur.mx_value} * 12'd10 + {4'd0, c - "0"};

  always_comb begin
    nxt    = cur;
    ph     = cur.phase;
    done   = 1'b0;
    vp     = cur.val_prog;
    vp_inc = 5'd0;
    tc     = 8'h00;
    len    = ssdp_pkg::MAN_LEN;

    if (ph == ssdp_pkg::PH_NAME) begin
      if (ssdp_pkg::is_token(c)) begin
        nxt.name_prog = ssdp_pkg::name_next(cur.name_prog, c);
        done = 1'b1;
      end else if (cur.name_prog == ssdp_pkg::NM_HOST) begin
        nxt.flags[ssdp_pkg::HF_HOST] = 1'b1;
        ph = ssdp_pkg::PH_SKIP;
      end else if (is_st) begin
        nxt.flags[ssdp_pkg::HF_ST] = 1'b1;
        ph = ssdp_pkg::PH_SEP1;
      end else if (cur.name_prog == ssdp_pkg::NM_MAN || cur.name_prog == ssdp_pkg::NM_MX) begin
        ph = ssdp_pkg::PH_SEP1;
      end else begin
        ph = ssdp_pkg::PH_SKIP;
      end
    end

    if (!done && ph == ssdp_pkg::PH_SEP1) begin
      if (c == " " || c == "\t") begin
        nxt.phase = ssdp_pkg::PH_SEP1;
        done = 1'b1;
      end else if (c == ":") begin
        done = 1'b1;
        if (cur.name_prog == ssdp_pkg::NM_MX) begin
          nxt.flags[ssdp_pkg::HF_MX] = 1'b1;
          nxt.mx_value = 8'd0;
          nxt.mx_neg   = 1'b0;
          nxt.phase    = ssdp_pkg::PH_MXPRE;
        end else begin
          nxt.val_prog = 5'd0;
          nxt.phase    = ssdp_pkg::PH_SEP2;
        end
      end else begin
        ph = ssdp_pkg::PH_SKIP;
      end
    end

    if (!done && ph == ssdp_pkg::PH_SEP2) begin
      if (c == " " || c == "\t") begin
        nxt.phase = ssdp_pkg::PH_SEP2;
        done = 1'b1;
      end else begin
        vp = 5'd0;
        nxt.val_prog = 5'd0;
        ph = ssdp_pkg::PH_VALUE;
      end
    end

    if (!done && ph == ssdp_pkg::PH_VALUE) begin
      if (is_st && vp[3:0] == 4'd0) begin
        // first st byte picks the target string
        if (c == "s") begin
          nxt.val_prog = 5'd1;
          nxt.phase = ssdp_pkg::PH_VALUE;
          done = 1'b1;
        end else if (c == "u") begin
          nxt.val_prog = 5'd17;
          nxt.phase = ssdp_pkg::PH_VALUE;
          done = 1'b1;
        end
      end else begin
        if (is_st && vp[4]) begin
          tc  = ssdp_pkg::st_root_char(vp[3:0]);
          len = ssdp_pkg::ST_ROOT_LEN;
        end else if (is_st) begin
          tc  = ssdp_pkg::st_all_char(vp[3:0]);
          len = ssdp_pkg::ST_ALL_LEN;
        end else begin
          tc  = ssdp_pkg::man_char(vp[3:0]);
          len = ssdp_pkg::MAN_LEN;
        end
        vp_inc = vp + 5'd1;
        if (c == tc) begin
          nxt.val_prog = vp_inc;
          done = 1'b1;
          if (vp_inc[3:0] == len) begin
            if (is_st) nxt.flags[ssdp_pkg::HF_MATCH] = 1'b1;
            else nxt.flags[ssdp_pkg::HF_MAN] = 1'b1;
            nxt.phase = ssdp_pkg::PH_SKIP;
          end else begin
            nxt.phase = ssdp_pkg::PH_VALUE;
          end
        end
      end
      if (!done) begin
        if (cur.name_prog == ssdp_pkg::NM_MAN) nxt.flags[ssdp_pkg::HF_BADMAN] = 1'b1;
        ph = ssdp_pkg::PH_SKIP;
      end
    end

    if (!done && ph == ssdp_pkg::PH_MXPRE) begin
      if (c == " " || c == "\t" || c == "\r" || c == 8'h0B || c == 8'h0C) begin
        nxt.phase = ssdp_pkg::PH_MXPRE;
        done = 1'b1;
      end else if (c == "+" || c == "-") begin
        nxt.mx_neg = (c == "-");
        nxt.phase  = ssdp_pkg::PH_MXDIG;
        done = 1'b1;
      end else begin
        ph = ssdp_pkg::is_digit(c) ? ssdp_pkg::PH_MXDIG : ssdp_pkg::PH_SKIP;
      end
    end

    if (!done && ph == ssdp_pkg::PH_MXDIG) begin
      if (ssdp_pkg::is_digit(c)) begin
        nxt.mx_value = (mx_wide > 12'd255) ? ssdp_pkg::MX_SAT : mx_wide[7:0];
        nxt.phase = ssdp_pkg::PH_MXDIG;
        done = 1'b1;
      end else begin
        ph = ssdp_pkg::PH_SKIP;
      end
    end

    if (!done) begin
      if (c == "\n") begin
        nxt.phase     = ssdp_pkg::PH_NAME;
        nxt.name_prog = ssdp_pkg::NM_IDLE;
        nxt.val_prog  = 5'd0;
      end else begin
        nxt.phase = ssdp_pkg::PH_SKIP;
      end
    end
  end

endmodule

// ===== hdl/ssdp_byte_step.sv =====
// next-state logic for one payload byte: notify scan, request line, headers
`timescale 1ns / 1ps

module ssdp_byte_step (
  input  logic [7:0]            c,
  input  ssdp_pkg::parse_state_t cur,
  output ssdp_pkg::parse_state_t nxt
);

  ssdp_pkg::hdr_state_t hdr_nxt;
  logic [2:0] np;
  logic       np_hit;

  ssdp_hdr_step u_hdr (
    .c   (c),
    .cur (cur.hdr),
    .nxt (hdr_nxt)
  );

  assign np_hit = (cur.notify_prog < ssdp_pkg::NOTIFY_LEN) &&
                  (c == ssdp_pkg::notify_char(cur.notify_prog));

  always_comb begin
    nxt = cur;
    np  = 3'd0;
    if (!cur.content_ended) begin
      if (c == 8'h00) begin
        nxt.content_ended = 1'b1;
      end else begin
        // notify scan
        if (np_hit) np = cur.notify_prog + 3'd1;
        else np = (c == "N") ? 3'd1 : 3'd0;
        if (np == ssdp_pkg::NOTIFY_LEN) begin
          nxt.notify_found = 1'b1;
          np = 3'd0;
        end
        nxt.notify_prog = np;

        // request line
        if (cur.rl_status < ssdp_pkg::RL_CHECK) begin
          if (c == ssdp_pkg::msearch_char(cur.rl_status[2:0]))
            nxt.rl_status = cur.rl_status + 4'd1;
          else
            nxt.rl_status = ssdp_pkg::RL_FAIL;
        end else if (cur.rl_status == ssdp_pkg::RL_CHECK) begin
          if (c >= 8'h21 && c <= 8'h7E) nxt.rl_status = ssdp_pkg::RL_FAIL;
          else nxt.rl_status = (c == "\n") ? ssdp_pkg::RL_HEAD : ssdp_pkg::RL_FIRST;
        end else if (cur.rl_status == ssdp_pkg::RL_FIRST) begin
          if (c == "\n") nxt.rl_status = ssdp_pkg::RL_HEAD;
        end else if (cur.rl_status == ssdp_pkg::RL_HEAD) begin
          nxt.hdr = hdr_nxt;
        end
      end
    end
  end

endmodule

// ===== hdl/ssdp_verdict.sv =====
// final verdict and reply delay from the parser state after the last byte
`timescale 1ns / 1ps

module ssdp_verdict (
  input  ssdp_pkg::parse_state_t st,
  output ssdp_pkg::verdict_t     verdict,
  output logic [6:0]             reply_delay
);

  logic bad_man;
  logic all_present;
  logic neg_mx;

  // man value still being matched when the datagram ends counts as bad
  assign bad_man = st.hdr.flags[ssdp_pkg::HF_BADMAN] ||
                   ((st.rl_status == ssdp_pkg::RL_HEAD) &&
                    (st.hdr.name_prog == ssdp_pkg::NM_MAN) &&
                    (st.hdr.phase == ssdp_pkg::PH_SEP2 ||
                     st.hdr.phase == ssdp_pkg::PH_VALUE));

  assign all_present = st.hdr.flags[ssdp_pkg::HF_HOST] && st.hdr.flags[ssdp_pkg::HF_ST] &&
                       st.hdr.flags[ssdp_pkg::HF_MAN] && st.hdr.flags[ssdp_pkg::HF_MX];

  assign neg_mx = st.hdr.mx_neg && (st.hdr.mx_value != 8'd0);

  always_comb begin
    reply_delay = 7'd0;
    if (st.notify_found) begin
      verdict = ssdp_pkg::V_NOTIFY;
    end else if (st.rl_status < ssdp_pkg::RL_CHECK || st.rl_status > ssdp_pkg::RL_HEAD) begin
      verdict = ssdp_pkg::V_NOT_MSRC;
    end else if (bad_man) begin
      verdict = ssdp_pkg::V_BAD_MAN;
    end else if (!all_present || neg_mx) begin
      verdict = ssdp_pkg::V_INVALID;
    end else if (!st.hdr.flags[ssdp_pkg::HF_MATCH]) begin
      verdict = ssdp_pkg::V_FOREIGN;
    end else begin
      verdict = ssdp_pkg::V_REPLY;
      reply_delay = (st.hdr.mx_value > ssdp_pkg::MX_LIMIT) ? ssdp_pkg::MX_LIMIT[6:0]
                                                           : st.hdr.mx_value[6:0];
    end
  end

endmodule

// ===== tb/ssdp_msearch_header_parser_tb.sv =====
// self-checking testbench for the ssdp m-search request checker
`timescale 1ns / 1ps

module ssdp_msearch_header_parser_tb;

  // run sizing
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_BYTES    = 450;
  localparam int RANDOM_VERDICTS = 4;
  localparam int QUIET_FROM      = 1;
  localparam int QUIET_LEN       = 2;

  // control characters used in payloads
  localparam logic [7:0] LF  = 8'h0a;
  localparam logic [7:0] CR  = 8'h0d;
  localparam logic [7:0] TAB = 8'h09;
  localparam logic [7:0] VT  = 8'h0b;
  localparam logic [7:0] FF  = 8'h0c;
  localparam logic [7:0] NUL = 8'h00;

  // value progress bit that selects the rootdevice target for st
  localparam logic [4:0] VP_ROOT = 5'd16;

  localparam string NOTIFY_TXT  = "NOTIFY ";
  localparam string MSEARCH_TXT = "M-SEARCH";
  localparam string ST_ALL_TXT  = "ssdp:all";
  localparam string ST_ROOT_TXT = "upnp:rootdevice";
  localparam string MAN_TXT     = "\"ssdp:discover\"";
  localparam string HDR_BASE    = "HOST:h\nST:ssdp:all\nMAN:\"ssdp:discover\"\n";

  typedef enum {HK_HOST, HK_ST, HK_MAN, HK_MX, HK_OTHER} hdr_kind_t;
  typedef enum {VM_FAIL, VM_MORE, VM_DONE} value_step_t;

  typedef struct {
    ssdp_pkg::verdict_t code;
    logic [6:0]         delay;
  } verdict_rec_t;

  // ---------------------------------------------------------------------------
  // scoreboard: tracks the parse of the datagram in flight and queues the
  // verdict each last byte should produce
  // ---------------------------------------------------------------------------
  class msearch_scoreboard;
    logic [2:0]            notify_prog;
    logic                  notify_seen;
    logic                  content_done;
    logic [3:0]            rl;
    ssdp_pkg::line_phase_t phase;
    logic [3:0]            name_prog;
    logic [4:0]            val_prog;
    logic [5:0]            flags;
    logic [7:0]            mx_mag;
    logic                  mx_minus;
    verdict_rec_t          pending[$];
    int                    errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      notify_prog  = 3'd0;
      notify_seen  = 1'b0;
      content_done = 1'b0;
      rl           = 4'd0;
      phase        = ssdp_pkg::PH_NAME;
      name_prog    = ssdp_pkg::NM_IDLE;
      val_prog     = 5'd0;
      flags        = 6'd0;
      mx_mag       = 8'd0;
      mx_minus     = 1'b0;
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_tok(logic [7:0] c);
      return is_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "_" || c == "-";
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || c == TAB;
    endfunction

    // case-folded walk toward host, st, man or mx
    function logic [3:0] next_name(logic [3:0] p, logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      case (p)
        ssdp_pkg::NM_IDLE: begin
          if (lc == "h") return ssdp_pkg::NM_H;
          if (lc == "s") return ssdp_pkg::NM_S;
          if (lc == "m") return ssdp_pkg::NM_M;
        end
        ssdp_pkg::NM_H:   if (lc == "o") return ssdp_pkg::NM_HO;
        ssdp_pkg::NM_HO:  if (lc == "s") return ssdp_pkg::NM_HOS;
        ssdp_pkg::NM_HOS: if (lc == "t") return ssdp_pkg::NM_HOST;
        ssdp_pkg::NM_S:   if (lc == "t") return ssdp_pkg::NM_ST;
        ssdp_pkg::NM_M: begin
          if (lc == "a") return ssdp_pkg::NM_MA;
          if (lc == "x") return ssdp_pkg::NM_MX;
        end
        ssdp_pkg::NM_MA:  if (lc == "n") return ssdp_pkg::NM_MAN;
        default: ;
      endcase
      return ssdp_pkg::NM_DEAD;
    endfunction

    function value_step_t match_value(logic [7:0] c);
      logic [4:0] vp;
      string      tgt;
      int         len;
      vp = val_prog;
      if (name_prog == ssdp_pkg::NM_ST) begin
        if (vp[3:0] == 4'd0) begin
          if (c == "s") vp = 5'd1;
          else if (c == "u") vp = VP_ROOT | 5'd1;
          else return VM_FAIL;
          val_prog = vp;
          return VM_MORE;
        end
        tgt = vp[4] ? ST_ROOT_TXT : ST_ALL_TXT;
      end else begin
        tgt = MAN_TXT;
      end
      len = tgt.len();
      if (c != tgt[vp[3:0]]) return VM_FAIL;
      vp = vp + 5'd1;
      val_prog = vp;
      return (int'(vp[3:0]) == len) ? VM_DONE : VM_MORE;
    endfunction

    // one byte of a header line; phases fall through as a byte is re-read
    function void header_byte(logic [7:0] c);
      ssdp_pkg::line_phase_t ph;
      value_step_t           r;
      int                    v;
      ph = phase;
      if (ph == ssdp_pkg::PH_NAME) begin
        if (is_tok(c)) begin
          name_prog = next_name(name_prog, c);
          return;
        end
        if (name_prog == ssdp_pkg::NM_HOST) begin
          flags[ssdp_pkg::HF_HOST] = 1'b1;
          ph = ssdp_pkg::PH_SKIP;
        end else if (name_prog == ssdp_pkg::NM_ST) begin
          flags[ssdp_pkg::HF_ST] = 1'b1;
          ph = ssdp_pkg::PH_SEP1;
        end else if (name_prog == ssdp_pkg::NM_MAN || name_prog == ssdp_pkg::NM_MX) begin
          ph = ssdp_pkg::PH_SEP1;
        end else begin
          ph = ssdp_pkg::PH_SKIP;
        end
      end
      if (ph == ssdp_pkg::PH_SEP1) begin
        if (is_blank(c)) begin
          phase = ph;
          return;
        end
        if (c == ":") begin
          if (name_prog == ssdp_pkg::NM_MX) begin
            flags[ssdp_pkg::HF_MX] = 1'b1;
            mx_mag   = 8'd0;
            mx_minus = 1'b0;
            phase    = ssdp_pkg::PH_MXPRE;
          end else begin
            val_prog = 5'd0;
            phase    = ssdp_pkg::PH_SEP2;
          end
          return;
        end
        ph = ssdp_pkg::PH_SKIP;
      end
      if (ph == ssdp_pkg::PH_SEP2) begin
        if (is_blank(c)) begin
          phase = ph;
          return;
        end
        val_prog = 5'd0;
        ph = ssdp_pkg::PH_VALUE;
      end
      if (ph == ssdp_pkg::PH_VALUE) begin
        r = match_value(c);
        if (r == VM_MORE) begin
          phase = ph;
          return;
        end
        if (r == VM_DONE) begin
          if (name_prog == ssdp_pkg::NM_ST) flags[ssdp_pkg::HF_MATCH] = 1'b1;
          else flags[ssdp_pkg::HF_MAN] = 1'b1;
          phase = ssdp_pkg::PH_SKIP;
          return;
        end
        if (name_prog == ssdp_pkg::NM_MAN) flags[ssdp_pkg::HF_BADMAN] = 1'b1;
        ph = ssdp_pkg::PH_SKIP;
      end
      if (ph == ssdp_pkg::PH_MXPRE) begin
        if (is_blank(c) || c == CR || c == VT || c == FF) begin
          phase = ph;
          return;
        end
        if (c == "+" || c == "-") begin
          mx_minus = (c == "-");
          phase = ssdp_pkg::PH_MXDIG;
          return;
        end
        ph = is_dig(c) ? ssdp_pkg::PH_MXDIG : ssdp_pkg::PH_SKIP;
      end
      if (ph == ssdp_pkg::PH_MXDIG) begin
        if (is_dig(c)) begin
          v = int'(mx_mag) * 10 + int'(c) - int'("0");
          mx_mag = (v > 255) ? 8'd255 : v[7:0];
          phase = ph;
          return;
        end
        ph = ssdp_pkg::PH_SKIP;
      end
      if (c == LF) begin
        phase     = ssdp_pkg::PH_NAME;
        name_prog = ssdp_pkg::NM_IDLE;
        val_prog  = 5'd0;
      end else begin
        phase = ssdp_pkg::PH_SKIP;
      end
    endfunction

    function void content_byte(logic [7:0] c);
      int np;
      np = int'(notify_prog);
      if (np < NOTIFY_TXT.len() && c == NOTIFY_TXT[np]) np++;
      else np = (c == "N") ? 1 : 0;
      if (np == NOTIFY_TXT.len()) begin
        notify_seen = 1'b1;
        np = 0;
      end
      notify_prog = np[2:0];

      if (rl < ssdp_pkg::RL_CHECK) begin
        if (c == MSEARCH_TXT[rl]) rl = rl + 4'd1;
        else rl = ssdp_pkg::RL_FAIL;
      end else if (rl == ssdp_pkg::RL_CHECK) begin
        if (c >= 8'h21 && c <= 8'h7e) rl = ssdp_pkg::RL_FAIL;
        else rl = (c == LF) ? ssdp_pkg::RL_HEAD : ssdp_pkg::RL_FIRST;
      end else if (rl == ssdp_pkg::RL_FIRST) begin
        if (c == LF) rl = ssdp_pkg::RL_HEAD;
      end else if (rl == ssdp_pkg::RL_HEAD) begin
        header_byte(c);
      end
    endfunction

    // accepted input byte; the last one queues a verdict
    function void note_byte(logic [7:0] c, logic last);
      logic [5:0]   hf;
      verdict_rec_t rec;
      if (!content_done) begin
        if (c == NUL) content_done = 1'b1;
        else content_byte(c);
      end
      if (!last) return;

      // a man value still open at the end counts as cut short
      hf = flags;
      if (rl == ssdp_pkg::RL_HEAD && name_prog == ssdp_pkg::NM_MAN &&
          (phase == ssdp_pkg::PH_SEP2 || phase == ssdp_pkg::PH_VALUE))
        hf[ssdp_pkg::HF_BADMAN] = 1'b1;

      rec.delay = 7'd0;
      if (notify_seen) rec.code = ssdp_pkg::V_NOTIFY;
      else if (rl < ssdp_pkg::RL_CHECK || rl > ssdp_pkg::RL_HEAD)
        rec.code = ssdp_pkg::V_NOT_MSRC;
      else if (hf[ssdp_pkg::HF_BADMAN]) rec.code = ssdp_pkg::V_BAD_MAN;
      else if (!(hf[ssdp_pkg::HF_HOST] && hf[ssdp_pkg::HF_ST] && hf[ssdp_pkg::HF_MAN] &&
                 hf[ssdp_pkg::HF_MX]) ||
               (mx_minus && mx_mag != 8'd0)) rec.code = ssdp_pkg::V_INVALID;
      else if (!hf[ssdp_pkg::HF_MATCH]) rec.code = ssdp_pkg::V_FOREIGN;
      else begin
        rec.code  = ssdp_pkg::V_REPLY;
        rec.delay = (mx_mag > ssdp_pkg::MX_LIMIT) ? ssdp_pkg::MX_LIMIT[6:0] : mx_mag[6:0];
      end
      pending.push_back(rec);
      clear_state();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic [2:0] v, logic [6:0] d);
      verdict_rec_t want;
      if (pending.size() == 0) begin
        report($sformatf("verdict %0d with no datagram waiting", v));
        return;
      end
      want = pending.pop_front();
      if (v !== want.code)
        report($sformatf("verdict %0d, expected %s", v, want.code.name()));
      if (d !== want.delay)
        report($sformatf("reply_delay %0d, expected %0d", d, want.delay));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // block and its signals
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] payload_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] verdict;
  logic [6:0] reply_delay;

  ssdp_msearch_header_parser uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .reply_delay  (reply_delay)
  );

  always #10 clk = ~clk;

  msearch_scoreboard sb = new();

  logic [7:0] dgram[$];    // datagram being assembled
  bit         quiet = 1'b0; // no idling on either side while set
  int         sent_bytes = 0;
  int         sent_dgrams = 0;
  int         stall_cycles = 0;

  // ---------------------------------------------------------------------------
  // monitors, sampled at the rising edge before any driver update
  // ---------------------------------------------------------------------------
  // result first, so a stray verdict cannot borrow the datagram that closes
  // at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_verdict(verdict, reply_delay);
      if (in_valid && in_ready) sb.note_byte(payload_byte, last_byte);
    end
  end

  // receiver back-pressure, ready drawn low with a chance of 8 in 100
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 8);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // datagram assembly helpers
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] c);
    dgram.push_back(c);
  endfunction

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) dgram.push_back(s[i]);
  endfunction

  function automatic void put_prefix(string s, int n);
    for (int i = 0; i < n && i < s.len(); i++) dgram.push_back(s[i]);
  endfunction

  // header names go out in random letter case
  function automatic void put_mixed(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1))
        c = c ^ 8'h20;
      dgram.push_back(c);
    end
  endfunction

  function automatic void put_blanks();
    int n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) put_byte($urandom_range(1) ? 8'h20 : TAB);
  endfunction

  function automatic void put_eol();
    if ($urandom_range(1)) put_byte(CR);
    put_byte(LF);
  endfunction

  // name to value separator; colon left out now and then
  function automatic void put_sep();
    put_blanks();
    if ($urandom_range(19) != 0) put(":");
    put_blanks();
  endfunction

  // full target, a prefix of it, or one byte changed
  function automatic void put_variant(string s);
    int r, k;
    r = $urandom_range(9);
    if (r < 7) begin
      put(s);
    end else if (r < 9) begin
      put_prefix(s, $urandom_range(s.len() - 1));
    end else begin
      k = $urandom_range(s.len() - 1);
      put_prefix(s, k);
      put_byte(8'($urandom_range(33, 126)));
      put(s.substr(k + 1, s.len() - 1));
    end
  endfunction

  function automatic void insert_text(string s, int n);
    int pos;
    pos = $urandom_range(dgram.size());
    for (int i = 0; i < n; i++) dgram.insert(pos + i, s[i]);
  endfunction

  function automatic void put_header(hdr_kind_t k);
    int r;
    case (k)
      HK_HOST: begin
        put_mixed("HOST");
        put_sep();
        put("239.255.255.250:1900");
      end
      HK_ST: begin
        put_mixed("ST");
        put_sep();
        r = $urandom_range(9);
        if (r < 4) put_variant(ST_ALL_TXT);
        else if (r < 7) put_variant(ST_ROOT_TXT);
        else if (r == 7) put("uuid:0a1b-22");
        else if (r == 8) put("urn:x");
      end
      HK_MAN: begin
        put_mixed("MAN");
        put_sep();
        if ($urandom_range(11) == 0) put("ssdp:discover");
        else put_variant(MAN_TXT);
      end
      HK_MX: begin
        put_mixed("MX");
        put_sep();
        // leading white space of every kind, then sign and digits
        repeat ($urandom_range(1)) begin
          r = $urandom_range(2);
          put_byte(r == 0 ? CR : r == 1 ? VT : FF);
        end
        r = $urandom_range(99);
        if (r >= 85) put("-");
        else if (r >= 70) put("+");
        repeat (($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(3))
          put_byte(8'($urandom_range(48, 57)));
      end
      default: begin
        case ($urandom_range(7))
          0: put("USER-AGENT");
          1: put_mixed("HOSTX");
          2: put("S");
          3: put("M");
          4: put_mixed("MA");
          5: put_mixed("MXY");
          6: put("X_1");
          default: put("hos");
        endcase
        put_sep();
        repeat ($urandom_range(6)) put_byte(8'($urandom_range(32, 126)));
      end
    endcase
    if ($urandom_range(4) == 0) put(" x");
    put_eol();
  endfunction

  // mostly well-formed request with random content and a few breakages
  function automatic void build_request();
    hdr_kind_t kinds[$];
    hdr_kind_t tmp;
    int        j, n, r;
    logic [7:0] sep;
    if ($urandom_range(99) < 4) begin
      put_prefix(MSEARCH_TXT, $urandom_range(7));
      put_byte(8'($urandom_range(255)));
    end else begin
      put(MSEARCH_TXT);
      r = $urandom_range(9);
      case (r)
        4: sep = TAB;
        5: sep = CR;
        6: sep = LF;
        7: sep = 8'($urandom_range(1, 31));
        8: sep = 8'($urandom_range(127, 255));
        9: sep = ($urandom_range(3) == 0) ? 8'($urandom_range(33, 126)) : 8'h20;
        default: sep = 8'h20;
      endcase
      put_byte(sep);
      if (sep != LF) begin
        put(" * HTTP/1.1");
        put_eol();
      end
    end

    if ($urandom_range(15) != 0) kinds.push_back(HK_HOST);
    if ($urandom_range(15) != 0) kinds.push_back(HK_ST);
    if ($urandom_range(15) != 0) kinds.push_back(HK_MAN);
    if ($urandom_range(15) != 0) kinds.push_back(HK_MX);
    if ($urandom_range(9) == 0) kinds.push_back(HK_MX);
    repeat ($urandom_range(2)) kinds.push_back(HK_OTHER);
    for (int i = kinds.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = kinds[i];
      kinds[i] = kinds[j];
      kinds[j] = tmp;
    end
    foreach (kinds[i]) put_header(kinds[i]);

    // stray nul ends content early
    if ($urandom_range(19) == 0) dgram.insert($urandom_range(dgram.size()), NUL);
    // datagram cut at a random point
    if ($urandom_range(15) == 0) begin
      n = $urandom_range(1, dgram.size());
      while (dgram.size() > n) void'(dgram.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] c, logic last);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= c;
    last_byte    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_dgram();
    int n;
    if (dgram.size() == 0) put_byte(8'($urandom_range(1, 255)));
    n = dgram.size();
    for (int i = 0; i < n; i++) send_byte(dgram[i], i == n - 1);
    sent_bytes += n;
    sent_dgrams++;
    dgram.delete();
  endtask

  task automatic send_text(string s);
    put(s);
    send_dgram();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain reply
    send_text({"M-SEARCH * HTTP/1.1\n", HDR_BASE, "MX:3\n"});
    // notify anywhere wins
    send_text("NOTIFY * HTTP/1.1\nHOST:h\n");
    send_text({"M-SEARCH\n", HDR_BASE, "NNOTIFY \n", "MX:1\n"});
    // too short, bare request word, printable after the request word
    send_text("M-SEAR");
    send_text("M-SEARCH");
    send_text({"M-SEARCHX\n", HDR_BASE, "MX:1\n"});
    // man value wrong, man cut short by the end of the datagram
    send_text("M-SEARCH\nHOST:h\nST:ssdp:all\nMAN:\"ssdp:disc\nMX:2\n");
    send_text("M-SEARCH\nHOST:h\nST:ssdp:all\nMX:2\nMAN: \"ss");
    // missing host, man without colon
    send_text("M-SEARCH\nST:ssdp:all\nMAN:\"ssdp:discover\"\nMX:2\n");
    send_text("M-SEARCH\nHOST:h\nST:ssdp:all\nMAN \"ssdp:discover\"\nMX:2\n");
    // negative mx, minus zero, saturation and clamp, last mx wins
    send_text({"M-SEARCH\n", HDR_BASE, "MX:-5\n"});
    send_text({"M-SEARCH\n", HDR_BASE, "MX:-0\n"});
    send_text({"M-SEARCH\n", HDR_BASE, "MX:99999\n"});
    send_text({"M-SEARCH\n", HDR_BASE, "MX:121\n"});
    send_text({"M-SEARCH\n", HDR_BASE, "MX: 120\n"});
    send_text({"M-SEARCH\n", HDR_BASE, "MX:5\nMX:7"});
    // uuid target and st without colon are not ours
    send_text("M-SEARCH\nHOST:h\nST:uuid:abc\nMAN:\"ssdp:discover\"\nMX:1\n");
    send_text("M-SEARCH\nHOST:h\nST\nMAN:\"ssdp:discover\"\nMX:1\n");
    // nul ends content, later notify is ignored
    put({"M-SEARCH\n", HDR_BASE, "MX:4\n"});
    put_byte(NUL);
    send_text("NOTIFY ");
    // mixed case names, rootdevice, odd white space before mx
    put("M-SEARCH\t*\nhost :h\nSt :\tupnp:rootdevice\nmAn: \"ssdp:discover\"\nmx:");
    put_byte(CR);
    put_byte(VT);
    put_byte(FF);
    send_text(" +7\n");
    // high byte after the request word, single byte datagrams
    put("M-SEARCH");
    put_byte(8'h80);
    send_text({"\n", HDR_BASE, "MX:9\n"});
    put_byte(8'hff);
    send_dgram();
    put_byte(NUL);
    send_dgram();

    // random part, with one stretch where neither side idles
    sent_bytes  = 0;
    sent_dgrams = 0;
    while (sent_bytes < RANDOM_BYTES || sent_dgrams < RANDOM_VERDICTS) begin
      quiet = (sent_dgrams >= QUIET_FROM) && (sent_dgrams < QUIET_FROM + QUIET_LEN);
      r = $urandom_range(99);
      if (r < 75) begin
        build_request();
      end else if (r < 88) begin
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
      end else begin
        build_request();
        insert_text(NOTIFY_TXT, ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 7);
      end
      send_dgram();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // let the last transfer reach the scoreboard, drain, then give the block
    // time to show any stray verdict
    repeat (2) @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== ssdp_msearch_header_parser.f =====
hdl/ssdp_pkg.sv
hdl/ssdp_hdr_step.sv
hdl/ssdp_byte_step.sv
hdl/ssdp_verdict.sv
hdl/ssdp_msearch_header_parser.sv
tb/ssdp_msearch_header_parser_tb.sv
